FILE: rtl/core/ccsl_pkg.sv
// ----------------------------------------------------------------------------
// ccsl_pkg
// Types, constants and helpers shared by the controller slew limiter files.
// ----------------------------------------------------------------------------
package ccsl_pkg;

	localparam int LANES_DEF = 5;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_INTERVAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP        = 2'd1;

	localparam logic [15:0] INTERVAL_RESET = 16'd100;
	localparam logic [14:0] STEP_RESET     = 15'd512;

	// Q7.8 values and scales
	localparam logic [8:0]  Q_ONE          = 9'd256;
	localparam logic [14:0] RESET_LANE0_Q8 = 15'd17920;
	localparam logic [14:0] RESET_OTHER_Q8 = 15'd15360;
	localparam logic [14:0] DRONE_BASE_Q8  = 15'd10240;
	localparam logic [14:0] DRONE_SCALE    = 15'd60;
	localparam logic [14:0] BRIGHT_BASE_Q8 = 15'd7680;
	localparam logic [14:0] BRIGHT_SCALE   = 15'd65;
	localparam logic [15:0] Q7_MAX         = 16'h7FFF;
	localparam logic [15:0] ROUND_HALF     = 16'd128;

	localparam logic [7:0] CC_MAX          = 8'd127;
	localparam logic [7:0] NOTHING_SENT    = 8'd255;
	localparam logic [6:0] CTRL_EXPRESSION = 7'd11;
	localparam logic [6:0] CTRL_BRIGHTNESS = 7'd74;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FLUSH
	} state_t;

	// One lane's record as kept in the lane memory
	typedef struct packed {
		logic [14:0] cur;
		logic [14:0] tgt;
		logic [31:0] emit_time;
		logic [7:0]  sent;
	} lane_rec_t;

	typedef struct packed {
		logic [3:0] midi_channel;
		logic [6:0] controller_number;
		logic [6:0] cc_value;
	} cc_item_t;

	// Item-wide controls for the lane update
	typedef struct packed {
		logic        is_tick;
		logic [31:0] now_ms;
		logic [15:0] interval;
		logic [14:0] step;
		logic [14:0] tgt0;
		logic [14:0] tgtn;
	} calc_ctl_t;

	typedef struct packed {
		logic hold_valid;
		logic out_free;
	} buf_stat_t;

	function automatic lane_rec_t lane_reset_rec(input logic is_lane0);
		lane_rec_t r;
		r.cur       = is_lane0 ? RESET_LANE0_Q8 : RESET_OTHER_Q8;
		r.tgt       = is_lane0 ? RESET_LANE0_Q8 : RESET_OTHER_Q8;
		r.emit_time = 32'd0;
		r.sent      = NOTHING_SENT;
		return r;
	endfunction

	function automatic logic [8:0] sat_fraction(input logic [8:0] f);
		return (f > Q_ONE) ? Q_ONE : f;
	endfunction

endpackage

FILE: rtl/core/ccsl_if.sv
// ----------------------------------------------------------------------------
// ccsl_if
// Handshake channels of the controller slew limiter: items, results, config.
// ----------------------------------------------------------------------------
interface ccsl_item_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [31:0] now_ms;
	logic [8:0]  brightness;
	logic [8:0]  drone_level;

	modport source (output valid, cmd, now_ms, brightness, drone_level, input ready);
	modport sink (input valid, cmd, now_ms, brightness, drone_level, output ready);
endinterface

interface ccsl_result_if;
	logic       valid;
	logic       ready;
	logic [3:0] midi_channel;
	logic [6:0] controller_number;
	logic [6:0] cc_value;
	logic       last_of_run;

	modport source (output valid, midi_channel, controller_number, cc_value, last_of_run,
		input ready);
	modport sink (input valid, midi_channel, controller_number, cc_value, last_of_run,
		output ready);
endinterface

interface ccsl_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  reg_index;
	logic [15:0] wdata;

	modport source (output valid, reg_index, wdata, input ready);
	modport sink (input valid, reg_index, wdata, output ready);
endinterface

FILE: rtl/core/ccsl_lane_mem.sv
// ----------------------------------------------------------------------------
// ccsl_lane_mem
// Lane record memory, registered read, per-entry valid bits.
// ----------------------------------------------------------------------------
module ccsl_lane_mem #(
	parameter int LANES = ccsl_pkg::LANES_DEF,
	parameter int LW    = 3
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_en,
	input  logic [LW-1:0]       rd_addr,
	output ccsl_pkg::lane_rec_t rd_data,
	input  logic                wr_en,
	input  logic [LW-1:0]       wr_addr,
	input  ccsl_pkg::lane_rec_t wr_data
);
	import ccsl_pkg::*;

	lane_rec_t        mem [LANES];
	lane_rec_t        rd_data_q;
	logic [LANES-1:0] vld_q;
	logic             rd_vld_q;
	logic             rd_lane0_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			rd_vld_q   <= 1'b0;
			rd_lane0_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q   <= vld_q[rd_addr];
				rd_lane0_q <= (rd_addr == '0);
			end
		end
	end

	// Never-written lanes read as their reset record
	assign rd_data = rd_vld_q ? rd_data_q : lane_reset_rec(rd_lane0_q);

endmodule

FILE: rtl/core/ccsl_lane_calc.sv
// ----------------------------------------------------------------------------
// ccsl_lane_calc
// Per-lane update: retarget, or due check, slew, rounding and emit decision.
// ----------------------------------------------------------------------------
module ccsl_lane_calc #(
	parameter int LW = 3
) (
	input  ccsl_pkg::calc_ctl_t ctl,
	input  logic [LW-1:0]       lane,
	input  ccsl_pkg::lane_rec_t rec_in,
	output ccsl_pkg::lane_rec_t rec_out,
	output logic                emit,
	output ccsl_pkg::cc_item_t  cc
);
	import ccsl_pkg::*;

	logic        is_lane0;
	logic [31:0] elapsed;
	logic        due;
	logic        up;
	logic [14:0] diff;
	logic        big;
	logic [15:0] sum_up;
	logic [14:0] val_up;
	logic [14:0] val_dn;
	logic [14:0] slewed;
	logic [15:0] rnd_sum;
	logic [7:0]  rnd;

	assign is_lane0 = (lane == '0);
	assign elapsed  = ctl.now_ms - rec_in.emit_time;
	assign due      = (elapsed >= {16'd0, ctl.interval});

	assign up     = (rec_in.tgt > rec_in.cur);
	assign diff   = up ? (rec_in.tgt - rec_in.cur) : (rec_in.cur - rec_in.tgt);
	assign big    = (diff > ctl.step);
	assign sum_up = {1'b0, rec_in.cur} + {1'b0, ctl.step};
	assign val_up = (sum_up > Q7_MAX) ? Q7_MAX[14:0] : sum_up[14:0];
	assign val_dn = rec_in.cur - ctl.step;
	assign slewed = big ? (up ? val_up : val_dn) : rec_in.tgt;

	// Round half up, clamp to the controller range
	assign rnd_sum = {1'b0, slewed} + ROUND_HALF;
	assign rnd     = (rnd_sum[15:8] > CC_MAX) ? CC_MAX : rnd_sum[15:8];

	always_comb begin
		rec_out = rec_in;
		emit    = 1'b0;
		if (!ctl.is_tick) begin
			rec_out.tgt = is_lane0 ? ctl.tgt0 : ctl.tgtn;
		end else if (due) begin
			rec_out.cur = slewed;
			if (rnd != rec_in.sent) begin
				emit              = 1'b1;
				rec_out.sent      = rnd;
				rec_out.emit_time = ctl.now_ms;
			end
		end
	end

	assign cc.midi_channel      = 4'(lane);
	assign cc.controller_number = is_lane0 ? CTRL_EXPRESSION : CTRL_BRIGHTNESS;
	assign cc.cc_value          = rnd[6:0];

endmodule

FILE: rtl/core/ccsl_emit_buf.sv
// ----------------------------------------------------------------------------
// ccsl_emit_buf
// Hold stage plus output register; marks the final result of a tick.
// ----------------------------------------------------------------------------
module ccsl_emit_buf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  ccsl_pkg::cc_item_t   push_item,
	input  logic                 flush,
	output ccsl_pkg::buf_stat_t  stat,
	ccsl_result_if.source        results
);
	import ccsl_pkg::*;

	cc_item_t hold_q;
	logic     hold_valid_q;
	cc_item_t out_q;
	logic     out_last_q;
	logic     out_valid_q;
	logic     out_free;
	logic     move;

	assign out_free = !out_valid_q || results.ready;
	// Move the held item out when a newer one arrives or the tick ends
	assign move = hold_valid_q && out_free && (push || flush);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (push) begin
				hold_valid_q <= 1'b1;
			end else if (move) begin
				hold_valid_q <= 1'b0;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			hold_q <= push_item;
		end
		if (move) begin
			out_q      <= hold_q;
			out_last_q <= !push;
		end
	end

	assign stat.hold_valid = hold_valid_q;
	assign stat.out_free   = out_free;

	assign results.valid             = out_valid_q;
	assign results.midi_channel      = out_q.midi_channel;
	assign results.controller_number = out_q.controller_number;
	assign results.cc_value          = out_q.cc_value;
	assign results.last_of_run       = out_last_q;

endmodule

FILE: rtl/core/multi_channel_cc_slew_limiter.sv
// Accepts one item at a time. A set-targets item (cmd 1) or a tick (cmd 0)
// sweeps the lane memory once, one lane per cycle unless the sweep stalls,
// and a tick then releases its final result before the next acceptance;
// the rate is set by the single read port of the lane memory. Each result
// stalls the sweep only while the output register is still full and the
// previous result is held behind it. A result is held one step so that the
// final one of a tick carries last_of_run; it leaves when the next emission
// or the end of the tick arrives. Configuration writes are taken in any
// cycle (cfg.ready is always high).
// ----------------------------------------------------------------------------
// multi_channel_cc_slew_limiter
// Five-lane MIDI controller slew limiter with targets from two fractions.
// ----------------------------------------------------------------------------
module multi_channel_cc_slew_limiter #(
	parameter int LANES = ccsl_pkg::LANES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	ccsl_item_if.sink      items,
	ccsl_result_if.source  results,
	ccsl_cfg_if.sink       cfg
);
	import ccsl_pkg::*;

	localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;
	localparam int CW = $clog2(LANES + 1);
	localparam logic [LW-1:0] LAST_LANE = LW'(LANES - 1);
	localparam logic [CW-1:0] LANE_COUNT = CW'(LANES);

	state_t      state_q;
	state_t      state_d;

	// Item-wide registers, loaded on acceptance
	logic        tick_q;
	logic [31:0] now_q;
	logic [14:0] tgt0_q;
	logic [14:0] tgtn_q;

	// Configuration
	logic [15:0] interval_q;
	logic [14:0] step_q;

	// Sweep control
	logic [CW-1:0] rd_cnt_q;
	logic          valid_s1;
	logic [LW-1:0] lane_s1;

	logic        accept;
	logic        issue;
	logic        flush;
	logic        stall;
	logic        lane_done;
	logic        emit;
	logic        push;
	logic [8:0]  bright_sat;
	logic [8:0]  drone_sat;
	lane_rec_t   rec_rd;
	lane_rec_t   rec_wr;
	cc_item_t    cc;
	calc_ctl_t   ctl;
	buf_stat_t   bstat;

	assign accept = items.valid && items.ready;

	// Hold the lane in place while its result cannot be parked
	assign stall     = valid_s1 && emit && bstat.hold_valid && !bstat.out_free;
	assign lane_done = valid_s1 && !stall;
	assign push      = lane_done && emit;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (items.valid) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (lane_done && (lane_s1 == LAST_LANE)) begin
					state_d = tick_q ? ST_FLUSH : ST_IDLE;
				end
			end
			ST_FLUSH: begin
				if (!bstat.hold_valid || bstat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State outputs
	always_comb begin
		items.ready = 1'b0;
		issue       = 1'b0;
		flush       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				items.ready = 1'b1;
			end
			ST_RUN: begin
				issue = (rd_cnt_q < LANE_COUNT) && !stall;
			end
			ST_FLUSH: begin
				flush = 1'b1;
			end
			default: begin
				items.ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			tick_q   <= 1'b0;
			rd_cnt_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= issue || (valid_s1 && stall);
			if (accept) begin
				tick_q   <= !items.cmd;
				rd_cnt_q <= '0;
			end else if (issue) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end
		end
	end

	// Targets in Q7.8 from saturated Q1.8 fractions
	assign bright_sat = sat_fraction(items.brightness);
	assign drone_sat  = sat_fraction(items.drone_level);

	always_ff @(posedge clk) begin
		if (accept) begin
			now_q  <= items.now_ms;
			tgt0_q <= DRONE_BASE_Q8 + DRONE_SCALE * {6'd0, drone_sat};
			tgtn_q <= BRIGHT_BASE_Q8 + BRIGHT_SCALE * {6'd0, bright_sat};
		end
		if (issue) begin
			lane_s1 <= rd_cnt_q[LW-1:0];
		end
	end

	// Configuration writes; unknown indexes are dropped
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= INTERVAL_RESET;
			step_q     <= STEP_RESET;
		end else if (cfg.valid) begin
			case (cfg.reg_index)
				CFG_UPDATE_INTERVAL: interval_q <= cfg.wdata;
				CFG_MAX_STEP:        step_q     <= cfg.wdata[14:0];
				default: begin
				end
			endcase
		end
	end

	assign ctl.is_tick  = tick_q;
	assign ctl.now_ms   = now_q;
	assign ctl.interval = interval_q;
	assign ctl.step     = step_q;
	assign ctl.tgt0     = tgt0_q;
	assign ctl.tgtn     = tgtn_q;

	// Read lane n while lane n-1 is modified and written back; a new item
	// starts only after the last write, so no entry is read while in flight.
	ccsl_lane_mem #(
		.LANES(LANES),
		.LW   (LW)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (issue),
		.rd_addr(rd_cnt_q[LW-1:0]),
		.rd_data(rec_rd),
		.wr_en  (lane_done),
		.wr_addr(lane_s1),
		.wr_data(rec_wr)
	);

	ccsl_lane_calc #(
		.LW(LW)
	) u_calc (
		.ctl    (ctl),
		.lane   (lane_s1),
		.rec_in (rec_rd),
		.rec_out(rec_wr),
		.emit   (emit),
		.cc     (cc)
	);

	ccsl_emit_buf u_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(cc),
		.flush    (flush),
		.stat     (bstat),
		.results  (results)
	);

`ifndef SYNTHESIS
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		items.ready |-> !valid_s1)
		else $error("lane in flight while accepting an item");

	a_set_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !tick_q) |-> !emit)
		else $error("set-targets item produced an emission");

	a_flush_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH) |-> (!valid_s1 && (rd_cnt_q == LANE_COUNT)))
		else $error("flush entered before the sweep finished");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rd_cnt_q <= LANE_COUNT)
		else $error("lane read counter overran");
`endif

endmodule
